@@ src/imh_pkg.sv @@
// shared constants, codes and types of the indexed min-heap
`default_nettype none
package imh_pkg;
    localparam int HEAP_SLOTS = 1024;
    localparam int ID_COUNT   = 1024;
    localparam int SLOT_W     = $clog2(HEAP_SLOTS);
    localparam int ID_W       = $clog2(ID_COUNT);
    localparam int KEY_W      = 32;

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_POP    = 2'd1;
    localparam logic [1:0] FN_UPDATE = 2'd2;
    localparam logic [1:0] FN_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;

    typedef struct packed {
        logic [SLOT_W-1:0]       h_ra;
        logic                    h_we;
        logic [SLOT_W-1:0]       h_wa;
        logic signed [KEY_W-1:0] h_wk;
        logic [ID_W-1:0]         h_wid;
        logic [ID_W-1:0]         p_ra;
        logic                    p_we;
        logic [ID_W-1:0]         p_wa;
        logic [SLOT_W-1:0]       p_wd;
    } t_mem_req;
endpackage
`default_nettype wire

@@ src/imh_store.sv @@
// heap slot memory and id position memory with registered reads
`default_nettype none
module imh_store import imh_pkg::*; (
    input  wire                      i_clk,
    input  t_mem_req                 i_req,
    output logic signed [KEY_W-1:0]  o_hq_k,
    output logic [ID_W-1:0]          o_hq_id,
    output logic [SLOT_W-1:0]        o_pq
);
    logic signed [KEY_W-1:0] r_keys [HEAP_SLOTS];
    logic [ID_W-1:0]         r_ids  [HEAP_SLOTS];
    logic [SLOT_W-1:0]       r_pos  [ID_COUNT];

    // heap slots
    always_ff @(posedge i_clk) begin
        if (i_req.h_we) begin
            r_keys[i_req.h_wa] <= i_req.h_wk;
            r_ids[i_req.h_wa]  <= i_req.h_wid;
        end
        o_hq_k  <= r_keys[i_req.h_ra];
        o_hq_id <= r_ids[i_req.h_ra];
    end

    // position table
    always_ff @(posedge i_clk) begin
        if (i_req.p_we) begin
            r_pos[i_req.p_wa] <= i_req.p_wd;
        end
        o_pq <= r_pos[i_req.p_ra];
    end
endmodule
`default_nettype wire

@@ src/indexed_min_heap_core.sv @@
// top level of the indexed min-heap priority queue
`default_nettype none
// Indexed binary min-heap of (key, id) pairs with a position table per id.
// A request is taken when i_start is high and o_busy is low; its result is
// shown for one cycle with o_done high and cannot be held off. After reset
// the position table is cleared one entry a cycle, and o_busy stays high
// until every entry is cleared. Every heap level costs one memory read (two
// for a sift-down step), all through a single read port on the slot memory;
// clear walks the held slots to reset their positions.
module indexed_min_heap_core import imh_pkg::*; (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    output logic                     o_busy,
    input  wire                      i_cfg_we,
    input  wire  [30:0]              i_cfg_data,
    input  wire  [1:0]               i_func,
    input  wire  [ID_W-1:0]          i_item_id,
    input  wire  signed [KEY_W-1:0]  i_key,
    output logic                     o_done,
    output logic [2:0]               o_status,
    output logic [ID_W-1:0]          o_popped_id,
    output logic signed [KEY_W-1:0]  o_min_key,
    output logic [SLOT_W-1:0]        o_count
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_INS_CHK, S_UP, S_UP_CMP, S_POP1, S_POP2,
        S_UPD_CHK, S_UPD_CUR, S_DN, S_DN_L, S_DN_R, S_CLR, S_FIN, S_OUT
    } t_state;

    t_state                  r_state, n_state;
    logic [ID_W-1:0]         r_id, n_id;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [SLOT_W-1:0]       r_hole, n_hole;
    logic [SLOT_W-1:0]       r_cnt, n_cnt;
    logic [SLOT_W-1:0]       r_idx, n_idx;
    logic [2:0]              r_status, n_status;
    logic [ID_W-1:0]         r_popped, n_popped;
    logic signed [KEY_W-1:0] r_ck, n_ck;
    logic [ID_W-1:0]         r_cid, n_cid;
    logic                    r_first, n_first;
    logic [30:0]             r_empty_key;

    t_mem_req                mreq;
    logic signed [KEY_W-1:0] hq_k;
    logic [ID_W-1:0]         hq_id;
    logic [SLOT_W-1:0]       pq;

    logic [SLOT_W:0]         child;
    logic signed [KEY_W-1:0] c_k;
    logic [ID_W-1:0]         c_id;
    logic [SLOT_W-1:0]       c_slot;
    logic                    do_cmp;

    imh_store u_store (
        .i_clk   (i_clk),
        .i_req   (mreq),
        .o_hq_k  (hq_k),
        .o_hq_id (hq_id),
        .o_pq    (pq)
    );

    assign child = {r_hole, 1'b0};

    // sequencer next state and memory requests
    always_comb begin
        n_state  = r_state;
        n_id     = r_id;
        n_key    = r_key;
        n_hole   = r_hole;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_status = r_status;
        n_popped = r_popped;
        n_ck     = r_ck;
        n_cid    = r_cid;
        n_first  = r_first;
        mreq     = '0;
        c_k      = r_ck;
        c_id     = r_cid;
        c_slot   = child[SLOT_W-1:0];
        do_cmp   = 1'b0;

        unique case (r_state)
            S_INIT: begin
                mreq.p_we = 1'b1;
                mreq.p_wa = r_idx;
                mreq.p_wd = '0;
                n_idx     = r_idx + 1'b1;
                if (&r_idx) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_id     = i_item_id;
                    n_key    = i_key;
                    n_status = ST_OK;
                    n_popped = '0;
                    n_first  = 1'b0;
                    mreq.p_ra = i_item_id;
                    unique case (i_func)
                        FN_INSERT: n_state = S_INS_CHK;
                        FN_UPDATE: n_state = S_UPD_CHK;
                        FN_POP: begin
                            mreq.h_ra = SLOT_W'(1);
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_POP1;
                            end
                        end
                        default: begin
                            mreq.h_ra = SLOT_W'(1);
                            n_idx     = SLOT_W'(1);
                            n_state   = (r_cnt == '0) ? S_FIN : S_CLR;
                        end
                    endcase
                end
            end
            S_INS_CHK: begin
                if (pq != '0) begin
                    n_status = ST_PRESENT;
                    n_state  = S_FIN;
                end else if (&r_cnt) begin
                    n_status = ST_FULL;
                    n_state  = S_FIN;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_hole  = r_cnt + 1'b1;
                    n_state = S_UP;
                end
            end
            S_UP: begin
                if (r_hole > SLOT_W'(1)) begin
                    mreq.h_ra = r_hole >> 1;
                    n_state   = S_UP_CMP;
                end else begin
                    mreq.h_we = 1'b1; mreq.h_wa = r_hole;
                    mreq.h_wk = r_key; mreq.h_wid = r_id;
                    mreq.p_we = 1'b1; mreq.p_wa = r_id; mreq.p_wd = r_hole;
                    n_state   = S_FIN;
                end
            end
            S_UP_CMP: begin
                n_first = 1'b0;
                if (r_key < hq_k) begin
                    // parent moves down into the hole
                    mreq.h_we = 1'b1; mreq.h_wa = r_hole;
                    mreq.h_wk = hq_k; mreq.h_wid = hq_id;
                    mreq.p_we = 1'b1; mreq.p_wa = hq_id; mreq.p_wd = r_hole;
                    n_hole    = r_hole >> 1;
                    n_state   = S_UP;
                end else if (r_first) begin
                    n_state = S_DN;
                end else begin
                    mreq.h_we = 1'b1; mreq.h_wa = r_hole;
                    mreq.h_wk = r_key; mreq.h_wid = r_id;
                    mreq.p_we = 1'b1; mreq.p_wa = r_id; mreq.p_wd = r_hole;
                    n_state   = S_FIN;
                end
            end
            S_POP1: begin
                n_popped  = hq_id;
                mreq.p_we = 1'b1;
                mreq.p_wa = hq_id;
                mreq.p_wd = '0;
                mreq.h_ra = r_cnt;
                n_cnt     = r_cnt - 1'b1;
                n_state   = (r_cnt == SLOT_W'(1)) ? S_FIN : S_POP2;
            end
            S_POP2: begin
                n_key   = hq_k;
                n_id    = hq_id;
                n_hole  = SLOT_W'(1);
                n_state = S_DN;
            end
            S_UPD_CHK: begin
                if (pq == '0) begin
                    n_status = ST_ABSENT;
                    n_state  = S_FIN;
                end else begin
                    n_hole    = pq;
                    mreq.h_ra = pq;
                    n_state   = S_UPD_CUR;
                end
            end
            S_UPD_CUR: begin
                if (hq_k == r_key) begin
                    n_state = S_FIN;
                end else if (r_hole > SLOT_W'(1)) begin
                    mreq.h_ra = r_hole >> 1;
                    n_first   = 1'b1;
                    n_state   = S_UP_CMP;
                end else begin
                    n_state = S_DN;
                end
            end
            S_DN: begin
                if (child > {1'b0, r_cnt}) begin
                    mreq.h_we = 1'b1; mreq.h_wa = r_hole;
                    mreq.h_wk = r_key; mreq.h_wid = r_id;
                    mreq.p_we = 1'b1; mreq.p_wa = r_id; mreq.p_wd = r_hole;
                    n_state   = S_FIN;
                end else begin
                    mreq.h_ra = child[SLOT_W-1:0];
                    n_state   = S_DN_L;
                end
            end
            S_DN_L: begin
                n_ck  = hq_k;
                n_cid = hq_id;
                if (child[SLOT_W-1:0] != r_cnt) begin
                    mreq.h_ra = child[SLOT_W-1:0] + 1'b1;
                    n_state   = S_DN_R;
                end else begin
                    c_k    = hq_k;
                    c_id   = hq_id;
                    do_cmp = 1'b1;
                end
            end
            S_DN_R: begin
                if (hq_k < r_ck) begin
                    c_k    = hq_k;
                    c_id   = hq_id;
                    c_slot = child[SLOT_W-1:0] + 1'b1;
                end
                do_cmp = 1'b1;
            end
            S_CLR: begin
                mreq.p_we = 1'b1;
                mreq.p_wa = hq_id;
                mreq.p_wd = '0;
                if (r_idx == r_cnt) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end else begin
                    mreq.h_ra = r_idx + 1'b1;
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_FIN: begin
                mreq.h_ra = SLOT_W'(1);
                n_state   = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // one sift-down step against the smaller child
        if (do_cmp) begin
            if (c_k < r_key) begin
                mreq.h_we = 1'b1; mreq.h_wa = r_hole;
                mreq.h_wk = c_k; mreq.h_wid = c_id;
                mreq.p_we = 1'b1; mreq.p_wa = c_id; mreq.p_wd = r_hole;
                n_hole    = c_slot;
                n_state   = S_DN;
            end else begin
                mreq.h_we = 1'b1; mreq.h_wa = r_hole;
                mreq.h_wk = r_key; mreq.h_wid = r_id;
                mreq.p_we = 1'b1; mreq.p_wa = r_id; mreq.p_wd = r_hole;
                n_state   = S_FIN;
            end
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_first     <= 1'b0;
            r_empty_key <= 31'd1000000000;
            o_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_first <= n_first;
            if (i_cfg_we) begin
                r_empty_key <= i_cfg_data;
            end
            o_done <= (r_state == S_OUT);
        end
        r_id     <= n_id;
        r_key    <= n_key;
        r_hole   <= n_hole;
        r_status <= n_status;
        r_popped <= n_popped;
        r_ck     <= n_ck;
        r_cid    <= n_cid;
        if (r_state == S_OUT) begin
            o_status    <= r_status;
            o_popped_id <= r_popped;
            o_min_key   <= (r_cnt != '0) ? hq_k : $signed({1'b0, r_empty_key});
            o_count     <= r_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

@@ sim/indexed_min_heap_core_test.sv @@
// self-checking testbench for the indexed min-heap priority queue core
`timescale 1ns / 100ps
`default_nettype none
module indexed_min_heap_core_test;
    import imh_pkg::*;

    typedef struct {
        logic [1:0]              func;
        logic [ID_W-1:0]         item_id;
        logic signed [KEY_W-1:0] key;
    } heap_req_t;

    typedef struct {
        logic [2:0]              status;
        logic [ID_W-1:0]         popped_id;
        logic signed [KEY_W-1:0] min_key;
        logic [SLOT_W-1:0]       count;
    } heap_resp_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_start = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [30:0]             i_cfg_data = '0;
    logic [1:0]              i_func = FN_INSERT;
    logic [ID_W-1:0]         i_item_id = '0;
    logic signed [KEY_W-1:0] i_key = '0;
    logic                    o_busy;
    logic                    o_done;
    logic [2:0]              o_status;
    logic [ID_W-1:0]         o_popped_id;
    logic signed [KEY_W-1:0] o_min_key;
    logic [SLOT_W-1:0]       o_count;

    indexed_min_heap_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_func(i_func), .i_item_id(i_item_id), .i_key(i_key),
        .o_done(o_done), .o_status(o_status), .o_popped_id(o_popped_id),
        .o_min_key(o_min_key), .o_count(o_count)
    );

    // predictor state: heap slots, slot of each id, fill level, empty report
    logic signed [KEY_W-1:0] heap_keys[HEAP_SLOTS];
    logic [ID_W-1:0]         heap_ids[HEAP_SLOTS];
    int                      slot_of[ID_COUNT];
    int                      held;
    logic [30:0]             blank_key = 31'd1000000000;

    heap_req_t  pending_reqs[$];
    heap_resp_t expected_results[$];
    int         errors = 0;
    int         idle_pct = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void put_slot(int s, logic signed [KEY_W-1:0] k, logic [ID_W-1:0] id);
        heap_keys[s] = k;
        heap_ids[s] = id;
        slot_of[id] = s;
    endfunction

    function automatic void bubble_up(int hole, logic signed [KEY_W-1:0] k,
                                      logic [ID_W-1:0] id);
        while (hole > 1 && k < heap_keys[hole / 2]) begin
            put_slot(hole, heap_keys[hole / 2], heap_ids[hole / 2]);
            hole = hole / 2;
        end
        put_slot(hole, k, id);
    endfunction

    function automatic void bubble_down(int hole, logic signed [KEY_W-1:0] k,
                                        logic [ID_W-1:0] id);
        int child;
        while (2 * hole <= held) begin
            child = 2 * hole;
            if (child != held && heap_keys[child + 1] < heap_keys[child])
                child++;
            if (!(heap_keys[child] < k))
                break;
            put_slot(hole, heap_keys[child], heap_ids[child]);
            hole = child;
        end
        put_slot(hole, k, id);
    endfunction

    // apply one request to the predictor and return the expected result
    function automatic heap_resp_t apply_request(heap_req_t r);
        heap_resp_t res;
        int p;
        int last;
        res.status = ST_OK;
        res.popped_id = '0;
        case (r.func)
            FN_INSERT: begin
                if (slot_of[r.item_id] != 0)
                    res.status = ST_PRESENT;
                else if (held + 1 >= HEAP_SLOTS)
                    res.status = ST_FULL;
                else begin
                    held++;
                    bubble_up(held, r.key, r.item_id);
                end
            end
            FN_POP: begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else begin
                    last = held;
                    res.popped_id = heap_ids[1];
                    slot_of[heap_ids[1]] = 0;
                    held--;
                    if (held != 0)
                        bubble_down(1, heap_keys[last], heap_ids[last]);
                end
            end
            FN_UPDATE: begin
                p = slot_of[r.item_id];
                if (p == 0)
                    res.status = ST_ABSENT;
                else if (heap_keys[p] != r.key) begin
                    if (p > 1 && r.key < heap_keys[p / 2])
                        bubble_up(p, r.key, r.item_id);
                    else
                        bubble_down(p, r.key, r.item_id);
                end
            end
            default: begin
                for (int i = 1; i <= held; i++)
                    slot_of[heap_ids[i]] = 0;
                held = 0;
            end
        endcase
        res.min_key = (held != 0) ? heap_keys[1] : {1'b0, blank_key};
        res.count = held[SLOT_W-1:0];
        return res;
    endfunction

    // driver: predict on acceptance, then present the next request or idle
    always @(posedge i_clk) begin
        heap_req_t r;
        logic accepted;
        accepted = i_start && !o_busy && i_rst_n;
        if (accepted) begin
            r.func = i_func;
            r.item_id = i_item_id;
            r.key = i_key;
            expected_results.push_back(apply_request(r));
        end
        if (!i_start || accepted) begin
            if (pending_reqs.size() != 0 && i_rst_n &&
                !(idle_pct != 0 && $urandom_range(99) < idle_pct)) begin
                r = pending_reqs.pop_front();
                i_start <= 1'b1;
                i_func <= r.func;
                i_item_id <= r.item_id;
                i_key <= r.key;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        heap_resp_t e;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status %0d count %0d",
                         $time, o_status, o_count);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_popped_id !== e.popped_id) begin
                    $display("%0t: popped_id expected %0d actual %0d",
                             $time, e.popped_id, o_popped_id);
                    errors++;
                end
                if (o_min_key !== e.min_key) begin
                    $display("%0t: min_key expected %0d actual %0d",
                             $time, e.min_key, o_min_key);
                    errors++;
                end
                if (o_count !== e.count) begin
                    $display("%0t: count expected %0d actual %0d", $time, e.count, o_count);
                    errors++;
                end
            end
        end
    end

    task automatic queue_req(logic [1:0] f, logic [ID_W-1:0] id, logic signed [KEY_W-1:0] k);
        heap_req_t r;
        r.func = f;
        r.item_id = id;
        r.key = k;
        pending_reqs.push_back(r);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(3))
            0: return $signed($urandom_range(16)) - 8;
            1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    // random mix; id_span keeps most ids in a range where hits are common
    task automatic queue_random(int n, int id_span, int clear_pct);
        int w;
        logic [ID_W-1:0] id;
        for (int i = 0; i < n; i++) begin
            w = $urandom_range(99);
            id = ($urandom_range(9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(id_span));
            if (w < clear_pct)
                queue_req(FN_CLEAR, ID_W'($urandom), $urandom);
            else if (w < 45)
                queue_req(FN_INSERT, id, pick_key());
            else if (w < 70)
                queue_req(FN_POP, ID_W'($urandom), $urandom);
            else
                queue_req(FN_UPDATE, id, pick_key());
        end
    endtask

    // hold off until every request has been answered and the core is idle
    task automatic drain();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || i_start || o_busy)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_empty_key(logic [30:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        blank_key = v;
    endtask

    initial begin
        for (int i = 0; i < ID_COUNT; i++)
            slot_of[i] = 0;
        held = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty cases, extremes, duplicates, equal and moving updates
        queue_req(FN_POP, '0, '0);
        queue_req(FN_UPDATE, 10'd3, 32'sd7);
        queue_req(FN_CLEAR, 10'h3ff, 32'sh7fffffff);
        queue_req(FN_INSERT, 10'd0, 32'sh80000000);
        queue_req(FN_INSERT, 10'h3ff, 32'sh7fffffff);
        queue_req(FN_INSERT, 10'd0, 32'sd1);
        queue_req(FN_INSERT, 10'd5, 32'sd0);
        queue_req(FN_INSERT, 10'd6, 32'sd0);
        queue_req(FN_UPDATE, 10'd5, 32'sd0);
        queue_req(FN_UPDATE, 10'h3ff, -32'sd5);
        queue_req(FN_UPDATE, 10'd0, 32'sh7fffffff);
        queue_req(FN_UPDATE, 10'd9, 32'sd0);
        queue_req(FN_POP, 10'h3ff, '1);
        queue_req(FN_POP, '0, '0);
        queue_req(FN_POP, '0, '0);
        queue_req(FN_POP, '0, '0);
        queue_req(FN_POP, '0, '0);
        queue_req(FN_INSERT, 10'h2aa, 32'sh55555555);
        queue_req(FN_INSERT, 10'h155, -32'sh55555555);
        queue_req(FN_CLEAR, '0, '0);
        queue_req(FN_POP, '0, '0);
        queue_random(150, 31, 4);
        drain();

        // deep heap, then duplicate inserts, moves and pops
        write_empty_key(31'd0);
        idle_pct = 69;
        for (int i = 0; i < 300; i++)
            queue_req(FN_INSERT, ID_W'(i), ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom);
        queue_req(FN_INSERT, ID_W'(ID_COUNT - 1), 32'sd1);
        queue_req(FN_INSERT, 10'd17, 32'sd1);
        for (int i = 0; i < 30; i++)
            queue_req(FN_UPDATE, ID_W'($urandom_range(299)), pick_key());
        for (int i = 0; i < 20; i++)
            queue_req(FN_POP, '0, '0);
        queue_req(FN_CLEAR, '0, '0);
        queue_random(100, 63, 3);
        drain();

        write_empty_key(31'h7fffffff);
        idle_pct = 69;
        queue_req(FN_POP, '0, '0);
        queue_random(120, 127, 2);
        drain();

        write_empty_key(31'($urandom));
        idle_pct = 35;
        queue_random(100, 255, 2);
        drain();

        write_empty_key(31'd1000000000);
        idle_pct = 0;
        queue_random(40, 15, 5);
        drain();
        repeat (40) @(posedge i_clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
src/imh_pkg.sv
src/imh_store.sv
src/indexed_min_heap_core.sv
sim/indexed_min_heap_core_test.sv
